/* hw/rtl/phm31_pkg.sv */
// ----------------------------------------------------------------------------
// phm31_pkg
// Shared types and constants for the Mersenne-31 polynomial hash block.
// ----------------------------------------------------------------------------
`default_nettype none

package phm31_pkg;

  localparam int KEY_W   = 32;
  localparam int HASH_W  = 31;
  localparam int CHUNK_W = 16;
  localparam int BYTE_W  = 8;

  localparam logic [HASH_W-1:0] MODULUS  = 31'h7FFF_FFFF;
  localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;

  localparam int DEF_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk;
    logic               last;
  } chunk_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/poly_hash_mod_mersenne31_top.sv */
// ----------------------------------------------------------------------------
// poly_hash_mod_mersenne31_top
// Keyed polynomial hash mod 2^31-1 over a byte stream, one hash per message.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one byte per transaction, with has_byte
// and last_flag. A last transaction pads the message and yields one hash.
// Config channel (cfg_valid/cfg_ready): writes hash_key and restarts the
// current message; always ready, write only while the block is idle.
// Output channel (out_valid/out_ready): one 31-bit hash per message.
// Flow: the front takes one byte per cycle into a short chunk queue while
// the queue has room and no pad chunk is pending; the hash engine takes
// each 16-bit chunk through add/reduce, multiply, fold and reduce, and
// accepts a new chunk only once it is through with the current one. When
// the last transaction completes a byte pair, a separate pad chunk is
// issued after it.
// A stalled receiver holds the hash in the output register; the engine then
// waits on the next final chunk while the front keeps filling the queue.
// Reset clears the key to 0, the accumulator, the queue and the output.
// ----------------------------------------------------------------------------
`default_nettype none

module poly_hash_mod_mersenne31_top #(
  parameter int QUEUE_DEPTH = phm31_pkg::DEF_QUEUE_DEPTH
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [7:0]                     data_byte,
  input  wire                            has_byte,
  input  wire                            last_flag,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [phm31_pkg::KEY_W-1:0]    hash_key,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [phm31_pkg::HASH_W-1:0]   hash_value
);
  import phm31_pkg::*;

  logic [KEY_W-1:0] key;
  logic             restart;
  logic             push_valid;
  logic             push_ready;
  chunk_cmd_t       push_cmd;
  logic             cmd_valid;
  logic             cmd_ready;
  chunk_cmd_t       cmd;

  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (restart) begin
      key <= hash_key;
    end
  end

  phm31_front u_front (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .has_byte   (has_byte),
    .last_flag  (last_flag),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  phm31_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_cmd),
    .rd_valid (cmd_valid),
    .rd_ready (cmd_ready),
    .rd_data  (cmd)
  );

  phm31_back u_back (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .key         (key),
    .restart_key (hash_key),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hash_value  (hash_value)
  );

endmodule

`default_nettype wire

/* hw/rtl/phm31_front.sv */
// ----------------------------------------------------------------------------
// phm31_front
// Accepts message bytes, pairs them into 16-bit chunks and issues chunk and
// padding commands to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module phm31_front (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            restart,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [7:0]                     data_byte,
  input  wire                            has_byte,
  input  wire                            last_flag,
  output logic                           push_valid,
  input  wire                            push_ready,
  output phm31_pkg::chunk_cmd_t          push_cmd
);
  import phm31_pkg::*;

  logic              half;
  logic              half_next;
  logic [BYTE_W-1:0] held;
  logic [BYTE_W-1:0] held_next;
  logic              pad_pend;
  logic              pad_pend_next;
  logic              accept;

  always_comb begin
    in_ready      = !pad_pend && push_ready;
    accept        = in_valid && in_ready;
    push_valid    = 1'b0;
    push_cmd.chunk = {{BYTE_W{1'b0}}, PAD_MARK};
    push_cmd.last  = 1'b1;
    half_next     = half;
    held_next     = held;
    pad_pend_next = pad_pend;
    if (pad_pend) begin
      push_valid    = 1'b1;
      pad_pend_next = !push_ready;
    end else if (accept) begin
      if (has_byte && half) begin
        push_valid     = 1'b1;
        push_cmd.chunk = {data_byte, held};
        push_cmd.last  = 1'b0;
        half_next      = 1'b0;
        pad_pend_next  = last_flag;
      end else if (has_byte && last_flag) begin
        push_valid     = 1'b1;
        push_cmd.chunk = {PAD_MARK, data_byte};
        half_next      = 1'b0;
      end else if (has_byte) begin
        held_next = data_byte;
        half_next = 1'b1;
      end else if (last_flag) begin
        push_valid     = 1'b1;
        push_cmd.chunk = half ? {PAD_MARK, held} : {{BYTE_W{1'b0}}, PAD_MARK};
        half_next      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      half     <= 1'b0;
      pad_pend <= 1'b0;
      held     <= '0;
    end else begin
      half     <= half_next;
      pad_pend <= pad_pend_next;
      held     <= held_next;
    end
  end

  a_pad_blocks_input: assert property (@(posedge clk) disable iff (rst)
    pad_pend |-> !in_ready)
    else $error("input accepted while padding chunk pending");

  a_pad_after_pair: assert property (@(posedge clk) disable iff (rst)
    (accept && has_byte && half && last_flag && !restart) |=> pad_pend)
    else $error("padding chunk not scheduled after final pair");

  a_pad_is_last: assert property (@(posedge clk) disable iff (rst)
    pad_pend |-> (push_valid && push_cmd.last))
    else $error("pending padding not issued as final chunk");

endmodule

`default_nettype wire

/* hw/rtl/phm31_fifo.sv */
// ----------------------------------------------------------------------------
// phm31_fifo
// Short command queue between the byte front end and the hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

module phm31_fifo #(
  parameter int DEPTH = phm31_pkg::DEF_QUEUE_DEPTH
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    wr_valid,
  output logic                   wr_ready,
  input  phm31_pkg::chunk_cmd_t  wr_data,
  output logic                   rd_valid,
  input  wire                    rd_ready,
  output phm31_pkg::chunk_cmd_t  rd_data
);
  import phm31_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  chunk_cmd_t      entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count not incremented on push");

endmodule

`default_nettype wire

/* hw/rtl/phm31_back.sv */
// ----------------------------------------------------------------------------
// phm31_back
// Horner engine: add chunk, reduce, multiply by key, reduce mod 2^31-1,
// and deliver the hash through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module phm31_back (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            restart,
  input  wire  [phm31_pkg::KEY_W-1:0]    key,
  input  wire  [phm31_pkg::KEY_W-1:0]    restart_key,
  input  wire                            cmd_valid,
  output logic                           cmd_ready,
  input  phm31_pkg::chunk_cmd_t          cmd,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [phm31_pkg::HASH_W-1:0]   hash_value
);
  import phm31_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_FOLD = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  function automatic logic [HASH_W-1:0] reduce33(input logic [HASH_W+1:0] x);
    logic [HASH_W:0] t;
    t = {1'b0, x[HASH_W-1:0]} + {{(HASH_W-1){1'b0}}, x[HASH_W+1:HASH_W]};
    if (t >= {1'b0, MODULUS}) begin
      t = t - {1'b0, MODULUS};
    end
    return t[HASH_W-1:0];
  endfunction

  logic [1:0]              state;
  logic [KEY_W-1:0]        acc;
  logic [HASH_W-1:0]       sum_red;
  logic [HASH_W+KEY_W-1:0] prod;
  logic [HASH_W+1:0]       fold;
  logic                    final_chunk;
  logic [HASH_W-1:0]       acc_new;
  logic                    out_free;

  assign cmd_ready = (state == ST_IDLE);
  assign acc_new   = reduce33(fold);
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sum_red     <= reduce33({1'b0, acc} + {{(HASH_W+2-CHUNK_W){1'b0}}, cmd.chunk});
        final_chunk <= cmd.last;
      end
      ST_MUL:  prod <= sum_red * key;
      ST_FOLD: fold <= {2'b00, prod[HASH_W-1:0]} + {1'b0, prod[HASH_W+KEY_W-1:HASH_W]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      acc        <= '0;
      out_valid  <= 1'b0;
      hash_value <= '0;
    end else begin
      if (state == ST_DONE && final_chunk && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (restart) begin
        acc <= restart_key;
      end else if (state == ST_DONE && !final_chunk) begin
        acc <= {1'b0, acc_new};
      end else if (state == ST_DONE && out_free) begin
        acc <= key;
      end
      case (state)
        ST_IDLE: if (cmd_valid) state <= ST_MUL;
        ST_MUL:  state <= ST_FOLD;
        ST_FOLD: state <= ST_DONE;
        ST_DONE: begin
          if (!final_chunk || out_free) begin
            state <= ST_IDLE;
          end
          if (final_chunk && out_free) begin
            hash_value <= acc_new;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_pop_starts_chunk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && cmd_valid) |=> (state == ST_MUL))
    else $error("chunk popped but engine did not start");

  a_hash_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hash_value != MODULUS))
    else $error("hash not fully reduced");

  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !final_chunk && !restart) |=> (acc < {1'b0, MODULUS}))
    else $error("accumulator not reduced after chunk");

  a_wait_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && final_chunk && !out_free) |=> (state == ST_DONE))
    else $error("final chunk dropped while output busy");

endmodule

`default_nettype wire

/* tb/poly_hash_mod_mersenne31_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_hash_mod_mersenne31_top_tb
// Self-checking bench for the Mersenne-31 polynomial hash block. Byte
// messages are queued per phase and driven over the input channel. Each
// accepted transaction steps a local Horner predictor, and every hash on
// the output channel is checked against the oldest predicted value. Phases
// change the key and the sender/receiver idle rates.
// ----------------------------------------------------------------------------

module poly_hash_mod_mersenne31_top_tb;

  import phm31_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE_CYC  = 20;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              has;
    logic              last;
  } byte_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              has_byte = 1'b0;
  logic              last_flag = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [KEY_W-1:0]  hash_key = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [HASH_W-1:0] hash_value;

  byte_item_t        pending_items[$];
  logic [HASH_W-1:0] expected_hashes[$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  logic in_taken = 1'b0;
  int idle_cycles = 0;
  int mismatch_count = 0;
  int items_taken = 0;
  int hashes_checked = 0;
  int key_writes = 0;

  logic [KEY_W-1:0]  key_m;
  logic [KEY_W-1:0]  acc_m;
  logic [BYTE_W-1:0] held_m;
  logic              half_m;

  poly_hash_mod_mersenne31_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .has_byte   (has_byte),
    .last_flag  (last_flag),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .hash_key   (hash_key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [KEY_W-1:0] fold_chunk(input logic [KEY_W-1:0] acc,
                                                  input logic [CHUNK_W-1:0] chunk,
                                                  input logic [KEY_W-1:0] key);
    logic [63:0] v;
    v = ({32'd0, acc} + {48'd0, chunk}) % {33'd0, MODULUS};
    v = (v * {32'd0, key}) % {33'd0, MODULUS};
    return v[KEY_W-1:0];
  endfunction

  task automatic rearm_hash();
    acc_m  = key_m;
    held_m = '0;
    half_m = 1'b0;
  endtask

  task automatic predict_hash(input byte_item_t it);
    if (it.has) begin
      if (half_m) begin
        acc_m  = fold_chunk(acc_m, {it.data, held_m}, key_m);
        held_m = '0;
        half_m = 1'b0;
      end else begin
        held_m = it.data;
        half_m = 1'b1;
      end
    end
    if (it.last) begin
      acc_m = fold_chunk(acc_m, half_m ? {PAD_MARK, held_m} : {8'h00, PAD_MARK}, key_m);
      expected_hashes.push_back(acc_m[HASH_W-1:0]);
      rearm_hash();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [HASH_W-1:0] got,
                                 input logic [HASH_W-1:0] want);
    $display("ERROR %0t: %s got 0x%08h expected 0x%08h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // driver: one nonblocking update per signal per falling edge
  always @(negedge clk) begin
    byte_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        it = pending_items.pop_front();
        in_valid  <= 1'b1;
        data_byte <= it.data;
        has_byte  <= it.has;
        last_flag <= it.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor and predictor
  always @(posedge clk) begin
    logic [HASH_W-1:0] want;
    if (rst) begin
      in_taken    <= 1'b0;
      idle_cycles <= 0;
      key_m = '0;
      rearm_hash();
    end else begin
      in_taken <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        key_m = hash_key;
        rearm_hash();
        key_writes++;
      end
      if (in_valid && in_ready) begin
        predict_hash('{data: data_byte, has: has_byte, last: last_flag});
        items_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_hashes.size() == 0) begin
          report_mismatch("unexpected hash", hash_value, '0);
        end else begin
          want = expected_hashes.pop_front();
          if (hash_value !== want) report_mismatch("hash_value", hash_value, want);
          hashes_checked++;
        end
      end
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("poly_hash_mod_mersenne31_top_tb NOT OK");
    $finish;
  end

  task automatic to_mid();
    @(posedge clk);
    #0.5;
  endtask

  task automatic wait_drained();
    to_mid();
    while (pending_items.size() > 0 || in_valid || expected_hashes.size() > 0) to_mid();
  endtask

  task automatic push_item(input logic [BYTE_W-1:0] d, input logic has, input logic last);
    pending_items.push_back('{data: d, has: has, last: last});
  endtask

  task automatic start_phase(input logic [KEY_W-1:0] key, input int s_pct, input int r_pct);
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    sender_idle_pct = s_pct;
    recv_stall_pct  = r_pct;
    @(negedge clk);
    cfg_valid <= 1'b1;
    hash_key  <= key;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
    to_mid();
  endtask

  task automatic queue_message(input int len, input bit end_with_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) push_item(BYTE_W'($urandom_range(255)), 1'b0, 1'b0);
      push_item(BYTE_W'($urandom_range(255)), 1'b1, (i == len - 1) && end_with_byte);
    end
    if (len == 0 || !end_with_byte) push_item(BYTE_W'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic queue_random(input int budget);
    int len;
    while (budget > 0) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      queue_message(len, 1'($urandom_range(1)));
      budget -= len + 1;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset key of zero
    to_mid();
    queue_message(0, 1'b0);
    queue_message(3, 1'b1);

    start_phase(32'h9E37_79B9, 0, 0);
    push_item(8'h5A, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b1);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hA5, 1'b0, 1'b1);
    push_item(8'h55, 1'b1, 1'b0);
    push_item(8'hAA, 1'b0, 1'b0);
    push_item(8'hAA, 1'b1, 1'b0);
    push_item(8'h0F, 1'b1, 1'b1);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'h80, 1'b1, 1'b0);
    push_item(8'h7F, 1'b1, 1'b0);
    push_item(8'h01, 1'b1, 1'b1);

    // key equal to the modulus: every product by the key reduces to zero
    start_phase({1'b0, MODULUS}, 76, 0);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'hFF, 1'b1, 1'b1);
    queue_random(70);

    start_phase(32'hFFFF_FFFF, 0, 76);
    queue_random(70);

    start_phase(32'h0000_0000, 31, 31);
    queue_random(60);

    start_phase(32'h0000_0001, 0, 0);
    queue_random(60);

    // sender holds off until all hashes are back, group by group
    start_phase($urandom, 31, 31);
    for (int g = 0; g < 8; g++) begin
      queue_random(8);
      wait_drained();
    end

    start_phase({1'b0, MODULUS} - 32'd1, 0, 76);
    queue_random(70);

    start_phase($urandom, 76, 0);
    queue_random(70);

    start_phase(32'h8000_0000, 31, 31);
    queue_random(60);

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);

    $display("ran %0d input transactions, %0d hashes checked, %0d key writes",
             items_taken, hashes_checked, key_writes);
    $display("keys covered zero, one, modulus, modulus-1, all ones, top bit and random");
    if (mismatch_count == 0 && expected_hashes.size() == 0) begin
      $display("poly_hash_mod_mersenne31_top_tb OK");
    end else begin
      $display("poly_hash_mod_mersenne31_top_tb NOT OK");
    end
    $finish;
  end

endmodule
